// ----- hdl/v3a_pkg.sv -----
`timescale 1ns / 1ps

package v3a_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int MW        = DW + 1;
  localparam int PW        = 2 * MW;
  localparam int SW        = PW + 2;
  localparam int SQ_STEPS  = DW;
  localparam int DIV_STEPS = DW;

  // pipeline stage indices, counted in register stages after the accept edge
  localparam int ST_LANE    = 2;
  localparam int ST_SQ_END  = ST_LANE + SQ_STEPS;
  localparam int ST_DIV_END = ST_SQ_END + 1 + DIV_STEPS;
  localparam int NSTG       = ST_DIV_END + 1;

  localparam logic [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_CMUL, OP_SDIV, OP_CDIV,
    OP_DOT, OP_CROSS, OP_LEN, OP_DIST, OP_NORM, OP_LERP, OP_EQ
  } op_t;

  typedef enum logic [1:0] {ST_OK, ST_OVF, ST_DIV0} status_t;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          ovf;
  } sat_t;

  typedef struct packed {
    op_t  cmd;
    logic eq;
    logic div0;
    logic big;
  } ctrl_t;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          ovf;
    logic [DW-1:0] qval;
    logic          qovf;
  } lane_out_t;

  function automatic sat_t sat32(input logic signed [SW-1:0] v);
    sat_t r;
    if (v > SMAX) begin
      r.val = QMAX;
      r.ovf = 1'b1;
    end else if (v < SMIN) begin
      r.val = QMIN;
      r.ovf = 1'b1;
    end else begin
      r.val = v[DW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- hdl/v3a_if.sv -----
`timescale 1ns / 1ps

interface v3a_in_if import v3a_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [3:0]           cmd;
  logic signed [DW-1:0] first_x;
  logic signed [DW-1:0] first_y;
  logic signed [DW-1:0] first_z;
  logic signed [DW-1:0] second_x;
  logic signed [DW-1:0] second_y;
  logic signed [DW-1:0] second_z;
  logic signed [DW-1:0] scalar_in;

  modport source (output valid, cmd, first_x, first_y, first_z,
                  second_x, second_y, second_z, scalar_in, input ready);
  modport sink (input valid, cmd, first_x, first_y, first_z,
                second_x, second_y, second_z, scalar_in, output ready);
endinterface

interface v3a_out_if import v3a_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] res_x;
  logic signed [DW-1:0] res_y;
  logic signed [DW-1:0] res_z;
  logic signed [DW-1:0] res_scalar;
  logic                 equal_flag;
  logic [1:0]           status;

  modport source (output valid, res_x, res_y, res_z, res_scalar, equal_flag, status,
                  input ready);
  modport sink (input valid, res_x, res_y, res_z, res_scalar, equal_flag, status,
                output ready);
endinterface

// ----- hdl/v3a_div.sv -----
`timescale 1ns / 1ps

module v3a_div import v3a_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] num_i,
  input  logic signed [MW-1:0] den_i,
  output sat_t                 q_o
);

  localparam int NW = DW + FRAC_BITS;

  logic [DW-1:0] rem_r  [DIV_STEPS+1];
  logic [DW-1:0] lo_r   [DIV_STEPS+1];
  logic [DW-1:0] q_r    [DIV_STEPS+1];
  logic [DW-1:0] dmag_r [DIV_STEPS+1];
  logic          neg_r  [DIV_STEPS+1];
  logic          big_r  [DIV_STEPS+1];

  logic [DW-1:0] rem_nxt [DIV_STEPS];
  logic          ge      [DIV_STEPS];

  logic [DW-1:0] nmag;
  logic [MW-1:0] dabs;
  logic [NW-1:0] nfull;
  logic [DW:0]   t;
  logic [DW-1:0] qf;
  logic          qovf;

  // setup: magnitudes, sign and quotient overflow check
  always_comb begin
    nmag  = num_i[DW-1] ? (~num_i + 1'b1) : num_i;
    dabs  = den_i[MW-1] ? (~den_i + 1'b1) : den_i;
    nfull = {nmag, {FRAC_BITS{1'b0}}};
  end

  // one restoring step per stage
  always_comb begin
    t = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t     = {rem_r[k], lo_r[k][DW-1]};
      ge[k] = t >= {1'b0, dmag_r[k]};
      rem_nxt[k] = ge[k] ? DW'(t - {1'b0, dmag_r[k]}) : t[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DW'(nfull[NW-1:DW]);
      lo_r[0]   <= nfull[DW-1:0];
      q_r[0]    <= '0;
      dmag_r[0] <= dabs[DW-1:0];
      neg_r[0]  <= num_i[DW-1] ^ den_i[MW-1];
      big_r[0]  <= DW'(nfull[NW-1:DW]) >= dabs[DW-1:0];
      for (int k = 1; k <= DIV_STEPS; k++) begin
        rem_r[k]  <= rem_nxt[k-1];
        lo_r[k]   <= {lo_r[k-1][DW-2:0], 1'b0};
        q_r[k]    <= {q_r[k-1][DW-2:0], ge[k-1]};
        dmag_r[k] <= dmag_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        big_r[k]  <= big_r[k-1];
      end
    end
  end

  always_comb begin
    qf   = q_r[DIV_STEPS];
    qovf = big_r[DIV_STEPS] ||
           (!neg_r[DIV_STEPS] && qf[DW-1]) ||
           (neg_r[DIV_STEPS] && qf[DW-1] && (|qf[DW-2:0]));
    q_o.ovf = qovf;
    if (qovf) begin
      q_o.val = neg_r[DIV_STEPS] ? QMIN : QMAX;
    end else begin
      q_o.val = neg_r[DIV_STEPS] ? (~qf + 1'b1) : qf;
    end
  end

endmodule

// ----- hdl/v3a_lane.sv -----
`timescale 1ns / 1ps

module v3a_lane import v3a_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  op_t                  cmd_i,
  input  logic signed [DW-1:0] a_i,
  input  logic signed [DW-1:0] b_i,
  input  logic signed [DW-1:0] s_i,
  input  logic signed [DW-1:0] cra_i,
  input  logic signed [DW-1:0] crb_i,
  input  logic signed [DW-1:0] crc_i,
  input  logic signed [DW-1:0] crd_i,
  output logic signed [PW-1:0] prod_o,
  input  logic [DW-1:0]        root_i,
  output lane_out_t            res_o
);

  localparam int RES_LEN = ST_DIV_END - ST_LANE + 1;
  localparam int OPR_LEN = ST_SQ_END - ST_LANE + 1;

  typedef struct packed {
    op_t                  cmd;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] dv;
  } opr_t;

  logic signed [MW-1:0] a_e, b_e, s_e, d_e;
  logic signed [MW-1:0] m0a_nxt, m0b_nxt, m1a_nxt, m1b_nxt, lin_nxt;
  logic signed [DW-1:0] dv_nxt;

  logic signed [MW-1:0] m0a_r, m0b_r, m1a_r, m1b_r, lin_r;
  op_t                  cmd1_r;
  logic signed [DW-1:0] a1_r, dv1_r;

  logic signed [PW-1:0] p0_r, p1_r;
  logic signed [MW-1:0] lin2_r;
  op_t                  cmd2_r;
  logic signed [DW-1:0] a2_r, dv2_r;

  logic signed [SW-1:0] p0x, p1x;
  sat_t                 sv_nxt;
  sat_t                 sv_r  [RES_LEN];
  opr_t                 opr_r [OPR_LEN];
  opr_t                 opr;
  logic signed [MW-1:0] den;
  sat_t                 q;

  assign a_e = MW'(a_i);
  assign b_e = MW'(b_i);
  assign s_e = MW'(s_i);
  assign d_e = a_e - b_e;

  always_comb begin
    lin_nxt = '0;
    m0a_nxt = '0;
    m0b_nxt = '0;
    m1a_nxt = '0;
    m1b_nxt = '0;
    dv_nxt  = '0;
    case (cmd_i)
      OP_ADD: lin_nxt = a_e + b_e;
      OP_SUB: lin_nxt = d_e;
      OP_NEG: lin_nxt = -a_e;
      OP_SCALE: begin
        m0a_nxt = a_e;
        m0b_nxt = s_e;
      end
      OP_CMUL, OP_DOT: begin
        m0a_nxt = a_e;
        m0b_nxt = b_e;
      end
      OP_CROSS: begin
        m0a_nxt = MW'(cra_i);
        m0b_nxt = MW'(crb_i);
        m1a_nxt = MW'(crc_i);
        m1b_nxt = MW'(crd_i);
      end
      OP_LEN, OP_NORM: begin
        m0a_nxt = a_e;
        m0b_nxt = a_e;
      end
      OP_DIST: begin
        m0a_nxt = d_e;
        m0b_nxt = d_e;
      end
      OP_LERP: begin
        m0a_nxt = b_e;
        m0b_nxt = s_e;
      end
      OP_SDIV: dv_nxt = s_i;
      OP_CDIV: dv_nxt = b_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0a_r  <= m0a_nxt;
      m0b_r  <= m0b_nxt;
      m1a_r  <= m1a_nxt;
      m1b_r  <= m1b_nxt;
      lin_r  <= lin_nxt;
      cmd1_r <= cmd_i;
      a1_r   <= a_i;
      dv1_r  <= dv_nxt;

      p0_r   <= m0a_r * m0b_r;
      p1_r   <= m1a_r * m1b_r;
      lin2_r <= lin_r;
      cmd2_r <= cmd1_r;
      a2_r   <= a1_r;
      dv2_r  <= dv1_r;
    end
  end

  assign prod_o = p0_r;
  assign p0x    = SW'(p0_r);
  assign p1x    = SW'(p1_r);

  always_comb begin
    sv_nxt = '0;
    case (cmd2_r)
      OP_ADD, OP_SUB, OP_NEG: sv_nxt = sat32(SW'(lin2_r));
      OP_SCALE, OP_CMUL:      sv_nxt = sat32(p0x >>> FRAC_BITS);
      OP_CROSS:               sv_nxt = sat32((p0x - p1x) >>> FRAC_BITS);
      OP_LERP:                sv_nxt = sat32(SW'(a2_r) + (p0x >>> FRAC_BITS));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r[0]  <= sv_nxt;
      opr_r[0] <= '{cmd: cmd2_r, a: a2_r, dv: dv2_r};
      for (int k = 1; k < RES_LEN; k++) begin
        sv_r[k] <= sv_r[k-1];
      end
      for (int k = 1; k < OPR_LEN; k++) begin
        opr_r[k] <= opr_r[k-1];
      end
    end
  end

  // divisor: scalar, second component or the vector length
  assign opr = opr_r[OPR_LEN-1];
  assign den = (opr.cmd == OP_NORM) ? {1'b0, root_i} : MW'(opr.dv);

  v3a_div u_div (
    .clk   (clk),
    .en    (en),
    .num_i (opr.a),
    .den_i (den),
    .q_o   (q)
  );

  assign res_o = '{val: sv_r[RES_LEN-1].val, ovf: sv_r[RES_LEN-1].ovf,
                   qval: q.val, qovf: q.ovf};

endmodule

// ----- hdl/v3a_merge.sv -----
`timescale 1ns / 1ps

module v3a_merge import v3a_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [PW-1:0] px_i,
  input  logic signed [PW-1:0] py_i,
  input  logic signed [PW-1:0] pz_i,
  output logic [DW-1:0]        root_mid_o,
  output logic [DW-1:0]        root_o,
  output sat_t                 dot_o
);

  localparam int RW       = DW + 1;
  localparam int NBW      = 2 * DW;
  localparam int DOT_LEN  = ST_DIV_END - ST_LANE;
  localparam int ROOT_LEN = ST_DIV_END - ST_SQ_END;

  logic signed [SW-1:0] sum_r;
  sat_t                 dot_r [DOT_LEN];
  logic [DW-1:0]        rd_r  [ROOT_LEN];

  logic [RW-1:0]  rem_r [SQ_STEPS];
  logic [DW-1:0]  rt_r  [SQ_STEPS];
  logic [NBW-1:0] n_r   [SQ_STEPS];

  logic [RW-1:0]  rem_nxt [SQ_STEPS];
  logic [DW-1:0]  rt_nxt  [SQ_STEPS];
  logic [NBW-1:0] n_nxt   [SQ_STEPS];

  logic [RW-1:0]  ri;
  logic [DW-1:0]  rti;
  logic [NBW-1:0] ni;
  logic [RW+1:0]  rsh;
  logic [RW+1:0]  trial;
  logic           ge;

  // digit-by-digit square root, two radicand bits per stage
  always_comb begin
    ri = '0; rti = '0; ni = '0; rsh = '0; trial = '0; ge = 1'b0;
    for (int k = 0; k < SQ_STEPS; k++) begin
      if (k == 0) begin
        ri  = '0;
        rti = '0;
        ni  = sum_r[NBW-1:0];
      end else begin
        ri  = rem_r[k-1];
        rti = rt_r[k-1];
        ni  = n_r[k-1];
      end
      rsh   = {ri, ni[NBW-1:NBW-2]};
      trial = (RW+2)'({rti, 2'b01});
      ge    = rsh >= trial;
      rem_nxt[k] = ge ? RW'(rsh - trial) : RW'(rsh);
      rt_nxt[k]  = {rti[DW-2:0], ge};
      n_nxt[k]   = {ni[NBW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= SW'(px_i) + SW'(py_i) + SW'(pz_i);
      for (int k = 0; k < SQ_STEPS; k++) begin
        rem_r[k] <= rem_nxt[k];
        rt_r[k]  <= rt_nxt[k];
        n_r[k]   <= n_nxt[k];
      end
      dot_r[0] <= sat32(sum_r >>> FRAC_BITS);
      for (int k = 1; k < DOT_LEN; k++) begin
        dot_r[k] <= dot_r[k-1];
      end
      rd_r[0] <= rt_r[SQ_STEPS-1];
      for (int k = 1; k < ROOT_LEN; k++) begin
        rd_r[k] <= rd_r[k-1];
      end
    end
  end

  assign root_mid_o = rt_r[SQ_STEPS-1];
  assign root_o     = rd_r[ROOT_LEN-1];
  assign dot_o      = dot_r[DOT_LEN-1];

endmodule

// ----- hdl/vec3_alu.sv -----
`timescale 1ns / 1ps
// Results leave through an output register on out_res.
// Throughput: one request per cycle unless the output stalls; the depth comes from
//   the 32-stage square root in the merge unit followed by the 32-stage divider in each lane.
// The pipeline keeps moving while a finished result waits, until the last stage fills.
// Reset: synchronous, active low; clears stage valid bits and the output valid only.

module vec3_alu import v3a_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  v3a_in_if.sink   in_req,
  v3a_out_if.source out_res
);

  logic              adv;
  logic [NSTG-1:0]   vld_r;
  ctrl_t             ctrl_r [NSTG];
  ctrl_t             ctrl_nxt;
  op_t               cmd;
  logic signed [MW-1:0] dx, dy, dz;

  logic signed [PW-1:0] px, py, pz;
  logic [DW-1:0]        root_mid, root;
  sat_t                 dot;
  lane_out_t            lx, ly, lz;

  ctrl_t                c;
  logic [DW-1:0]        fx, fy, fz, fsc;
  logic                 feq;
  status_t              fst;

  logic                 out_valid_r;
  logic [DW-1:0]        res_x_r, res_y_r, res_z_r, res_sc_r;
  logic                 eq_r;
  status_t              st_r;

  assign adv          = out_res.ready || !out_valid_r || !vld_r[NSTG-1];
  assign in_req.ready = adv;
  assign cmd          = op_t'(in_req.cmd);

  assign dx = MW'(in_req.first_x) - MW'(in_req.second_x);
  assign dy = MW'(in_req.first_y) - MW'(in_req.second_y);
  assign dz = MW'(in_req.first_z) - MW'(in_req.second_z);

  always_comb begin
    ctrl_nxt.cmd = cmd;
    ctrl_nxt.eq  = (in_req.first_x == in_req.second_x) &&
                   (in_req.first_y == in_req.second_y) &&
                   (in_req.first_z == in_req.second_z);
    ctrl_nxt.big = (dx > MW'(SMAX)) || (dx <= MW'(SMIN)) ||
                   (dy > MW'(SMAX)) || (dy <= MW'(SMIN)) ||
                   (dz > MW'(SMAX)) || (dz <= MW'(SMIN));
    case (cmd)
      OP_SDIV: ctrl_nxt.div0 = (in_req.scalar_in == '0);
      OP_CDIV: ctrl_nxt.div0 = (in_req.second_x == '0) || (in_req.second_y == '0) ||
                               (in_req.second_z == '0);
      OP_NORM: ctrl_nxt.div0 = (in_req.first_x == '0) && (in_req.first_y == '0) &&
                               (in_req.first_z == '0);
      default: ctrl_nxt.div0 = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl_r[0] <= ctrl_nxt;
      for (int k = 1; k < NSTG; k++) begin
        ctrl_r[k] <= ctrl_r[k-1];
      end
    end
  end

  v3a_lane u_lane_x (
    .clk (clk), .en (adv), .cmd_i (cmd),
    .a_i (in_req.first_x), .b_i (in_req.second_x), .s_i (in_req.scalar_in),
    .cra_i (in_req.first_y), .crb_i (in_req.second_z),
    .crc_i (in_req.first_z), .crd_i (in_req.second_y),
    .prod_o (px), .root_i (root_mid), .res_o (lx)
  );

  v3a_lane u_lane_y (
    .clk (clk), .en (adv), .cmd_i (cmd),
    .a_i (in_req.first_y), .b_i (in_req.second_y), .s_i (in_req.scalar_in),
    .cra_i (in_req.first_z), .crb_i (in_req.second_x),
    .crc_i (in_req.first_x), .crd_i (in_req.second_z),
    .prod_o (py), .root_i (root_mid), .res_o (ly)
  );

  v3a_lane u_lane_z (
    .clk (clk), .en (adv), .cmd_i (cmd),
    .a_i (in_req.first_z), .b_i (in_req.second_z), .s_i (in_req.scalar_in),
    .cra_i (in_req.first_x), .crb_i (in_req.second_y),
    .crc_i (in_req.first_y), .crd_i (in_req.second_x),
    .prod_o (pz), .root_i (root_mid), .res_o (lz)
  );

  v3a_merge u_merge (
    .clk        (clk),
    .en         (adv),
    .px_i       (px),
    .py_i       (py),
    .pz_i       (pz),
    .root_mid_o (root_mid),
    .root_o     (root),
    .dot_o      (dot)
  );

  always_comb begin
    c   = ctrl_r[NSTG-1];
    fx  = '0;
    fy  = '0;
    fz  = '0;
    fsc = '0;
    feq = 1'b0;
    fst = ST_OK;
    case (c.cmd)
      OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_CMUL, OP_CROSS, OP_LERP: begin
        fx = lx.val;
        fy = ly.val;
        fz = lz.val;
        if (lx.ovf || ly.ovf || lz.ovf) fst = ST_OVF;
      end
      OP_SDIV, OP_CDIV, OP_NORM: begin
        if (c.div0) begin
          fst = ST_DIV0;
        end else begin
          fx = lx.qval;
          fy = ly.qval;
          fz = lz.qval;
          if (lx.qovf || ly.qovf || lz.qovf) fst = ST_OVF;
        end
      end
      OP_DOT: begin
        fsc = dot.val;
        if (dot.ovf) fst = ST_OVF;
      end
      OP_LEN: begin
        if (root[DW-1]) begin
          fsc = QMAX;
          fst = ST_OVF;
        end else begin
          fsc = root;
        end
      end
      OP_DIST: begin
        if (c.big || root[DW-1]) begin
          fsc = QMAX;
          fst = ST_OVF;
        end else begin
          fsc = root;
        end
      end
      OP_EQ: feq = c.eq;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_res.ready || !out_valid_r) begin
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_res.ready || !out_valid_r) begin
      res_x_r  <= fx;
      res_y_r  <= fy;
      res_z_r  <= fz;
      res_sc_r <= fsc;
      eq_r     <= feq;
      st_r     <= fst;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.res_x      = res_x_r;
  assign out_res.res_y      = res_y_r;
  assign out_res.res_z      = res_z_r;
  assign out_res.res_scalar = res_sc_r;
  assign out_res.equal_flag = eq_r;
  assign out_res.status     = st_r;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> out_res.valid && !out_res.ready)
    else $error("input stalled while the output can drain");

  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.status == ST_DIV0 |->
      out_res.res_x == '0 && out_res.res_y == '0 && out_res.res_z == '0 &&
      out_res.res_scalar == '0 && !out_res.equal_flag)
    else $error("divide by zero result not cleared");

  a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.equal_flag |->
      out_res.status == ST_OK && out_res.res_scalar == '0 && out_res.res_x == '0)
    else $error("equality result carries other data");
`endif

endmodule
